[hdl/mbst_pkg.sv]
// Package for the magnetometer bias self-test gain block.
// Holds payload structs, phase and sequencer enums and shared constants.
package mbst_pkg;

    localparam int SAMPLES_PER_PHASE_DEF  = 10;
    localparam int GAIN_FRACTION_BITS_DEF = 14;
    localparam int SUM_W = 21;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_XY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Z    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LIM  = 2'd2;
    localparam logic [15:0] REF_XY_RST  = 16'd15312;
    localparam logic [15:0] REF_Z_RST   = 16'd14256;
    localparam logic [15:0] SAT_LIM_RST = 16'hF000;
    localparam logic        REQ_START = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE, PH_DISCARD, PH_POSITIVE, PH_NEGATIVE
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCALE, ST_DIV, ST_DIV_NEXT, ST_OUT
    } seq_t;

    typedef struct packed {
        logic       req_type;
        logic       bus_ack;
        logic [7:0] byte_x_high;
        logic [7:0] byte_x_low;
        logic [7:0] byte_z_high;
        logic [7:0] byte_z_low;
        logic [7:0] byte_y_high;
        logic [7:0] byte_y_low;
    } in_word_t;

    typedef struct packed {
        logic               reading_valid;
        logic signed [15:0] field_x;
        logic signed [15:0] field_y;
        logic signed [15:0] field_z;
        logic               calibrating;
        logic               calibration_failed;
    } out_word_t;

    typedef struct packed {
        logic       start;
        logic [1:0] axis;
    } div_ctl_t;

endpackage

[hdl/mbst_div.sv]
// Restoring divider, one quotient bit per cycle.
// Computes min(65535, (ref << FRAC) / |total|); depends on mbst_pkg.
module mbst_div
    import mbst_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  div_ctl_t                ctl,
    input  logic [15:0]             numer,
    input  logic signed [SUM_W-1:0] total,
    output logic                    done,
    output logic [15:0]             quot
);
    localparam int NW = 16 + GAIN_FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]    num_reg, num_next;
    logic [NW-1:0]    q_reg, q_next;
    logic [SUM_W:0]   rem_reg, rem_next;
    logic [SUM_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   diff;

    always_comb begin
        trial = {rem_reg[SUM_W-1:0], num_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
    end

    always_comb begin
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctl.start) begin
            num_next  = {numer, {GAIN_FRACTION_BITS{1'b0}}};
            q_next    = '0;
            rem_next  = '0;
            den_next  = total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            if (!diff[SUM_W]) begin
                rem_next = diff;
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = !busy_reg && !ctl.start;
    assign quot = (den_reg == '0 || q_reg[NW-1:16] != '0) ? 16'hFFFF : q_reg[15:0];

    always_ff @(posedge aclk) begin
        if (aresetn && busy_reg) begin
            assert (!ctl.start) else $error("divider restarted while busy");
        end
    end
endmodule

[hdl/magnetometer_bias_self_test_gain.sv]
// Top level of the magnetometer bias self-test gain block.
// Uses mbst_pkg and mbst_div (shared divider for the three gains).
//
// Usage: words enter on s_valid/s_ready/s_data and results leave on
// m_valid/m_ready/m_data, one result word per input word. A start word
// (req_type 0) sets gains to unity and runs the self-test over the next
// reads: one discarded, up to SAMPLES_PER_PHASE added, up to
// SAMPLES_PER_PHASE subtracted. Normal reads while idle give gain-scaled
// fields, one axis multiply per cycle through a single shared multiplier.
// Sequence: an acknowledged read while idle passes through ST_SCALE once per
// axis and then ST_OUT before m_valid, any other word through ST_OUT alone;
// the word that closes the self-test without saturation runs the bit-serial
// divider, shared over three axes, once per axis (ST_DIV, ST_DIV_NEXT).
// Throughput: one word at a time; s_ready is low until the result is taken.
// Reset (aresetn low, synchronous) restores default registers, unity gains
// and the idle phase. A stalled receiver holds the result word in the
// output register and keeps s_ready low.
// Configuration writes via cfg_we/cfg_index/cfg_data while idle.
module magnetometer_bias_self_test_gain
    import mbst_pkg::*;
#(
    parameter int SAMPLES_PER_PHASE  = SAMPLES_PER_PHASE_DEF,
    parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);
    localparam logic [3:0] NSAMP = 4'(SAMPLES_PER_PHASE);
    localparam logic [15:0] UNITY = 16'(1 << GAIN_FRACTION_BITS);

    seq_t   st_reg, st_next;
    phase_t ph_reg, ph_next;
    logic [15:0] ref_xy_reg, ref_z_reg;
    logic signed [15:0] sat_lim_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [SUM_W-1:0] sum_next [3];
    logic [15:0] gain_reg [3];
    logic signed [15:0] last_reg [3];
    logic signed [15:0] last_next [3];
    logic signed [15:0] fld_reg [3];
    logic        sat_reg, sat_next;
    logic [1:0]  ax_reg;
    logic        valid_reg, calib_reg;
    logic        mv_reg;
    out_word_t   out_reg;
    logic        accept;
    logic        start_div, start_div_next;
    div_ctl_t    dctl;
    logic        ddone;
    logic [15:0] dquot;
    logic signed [16:0] mul_b;
    logic signed [33:0] prod;
    logic [33:0] pmag;
    logic signed [33:0] sres;
    logic signed [15:0] sclip;
    logic        sat_now;
    logic        finish;

    assign accept  = s_valid && s_ready;
    assign s_ready = (st_reg == ST_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_xy_reg  <= REF_XY_RST;
            ref_z_reg   <= REF_Z_RST;
            sat_lim_reg <= SAT_LIM_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_REF_XY:  ref_xy_reg  <= cfg_data;
                CFG_REF_Z:   ref_z_reg   <= cfg_data;
                CFG_SAT_LIM: sat_lim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input step: phase update on accept.
    always_comb begin
        ph_next  = ph_reg;
        cnt_next = cnt_reg;
        sat_next = sat_reg;
        finish   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sum_next[i]  = sum_reg[i];
            last_next[i] = last_reg[i];
        end
        if (s_data.bus_ack) begin
            last_next[0] = {s_data.byte_x_high, s_data.byte_x_low};
            last_next[2] = {s_data.byte_z_high, s_data.byte_z_low};
            last_next[1] = {s_data.byte_y_high, s_data.byte_y_low};
        end
        sat_now = last_next[0] <= sat_lim_reg || last_next[1] <= sat_lim_reg
               || last_next[2] <= sat_lim_reg;
        if (s_data.req_type == REQ_START) begin
            ph_next  = PH_DISCARD;
            cnt_next = '0;
            sat_next = 1'b0;
            for (int i = 0; i < 3; i++) begin
                sum_next[i]  = '0;
                last_next[i] = last_reg[i];
            end
        end else begin
            unique case (ph_reg)
                PH_IDLE: ;
                PH_DISCARD: begin
                    ph_next  = PH_POSITIVE;
                    cnt_next = '0;
                end
                PH_POSITIVE, PH_NEGATIVE: begin
                    cnt_next = cnt_reg + 4'd1;
                    for (int i = 0; i < 3; i++) begin
                        if (ph_reg == PH_POSITIVE) begin
                            sum_next[i] = sum_reg[i] + SUM_W'(last_next[i]);
                        end else begin
                            sum_next[i] = sum_reg[i] - SUM_W'(last_next[i]);
                        end
                    end
                    if (sat_now) begin
                        sat_next = 1'b1;
                    end
                    if (sat_now || cnt_next >= NSAMP) begin
                        cnt_next = '0;
                        ph_next  = (ph_reg == PH_POSITIVE) ? PH_NEGATIVE : PH_IDLE;
                        finish   = (ph_reg == PH_NEGATIVE);
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.req_type != REQ_START && ph_reg == PH_IDLE
                        && s_data.bus_ack) begin
                        st_next = ST_SCALE;
                    end else if (finish && !sat_next) begin
                        st_next = ST_DIV;
                    end else begin
                        st_next = ST_OUT;
                    end
                end
            end
            ST_SCALE:    st_next = (ax_reg == 2'd2) ? ST_OUT : ST_SCALE;
            ST_DIV:      st_next = ddone ? ST_DIV_NEXT : ST_DIV;
            ST_DIV_NEXT: st_next = (ax_reg == 2'd2) ? ST_OUT : ST_DIV;
            ST_OUT:      st_next = ST_IDLE;
            default:     st_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        start_div_next = 1'b0;
        unique case (st_reg)
            ST_IDLE:     start_div_next = accept && finish && !sat_next;
            ST_DIV_NEXT: start_div_next = (ax_reg != 2'd2);
            default:     start_div_next = 1'b0;
        endcase
    end

    assign dctl.start = start_div;
    assign dctl.axis  = ax_reg;

    mbst_div #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (dctl),
        .numer  ((ax_reg == 2'd2) ? ref_z_reg : ref_xy_reg),
        .total  (sum_reg[ax_reg]),
        .done   (ddone),
        .quot   (dquot)
    );

    // Shared multiplier, one axis per cycle.
    always_comb begin
        mul_b = {1'b0, gain_reg[ax_reg]};
        prod  = 34'(last_reg[ax_reg]) * 34'(mul_b);
        pmag  = prod[33] ? 34'(-prod) : 34'(prod);
        pmag  = pmag >> GAIN_FRACTION_BITS;
        sres  = prod[33] ? -$signed(pmag) : $signed(pmag);
        if (sres > 34'sd32767) begin
            sclip = 16'sh7FFF;
        end else if (sres < -34'sd32768) begin
            sclip = 16'sh8000;
        end else begin
            sclip = sres[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            ph_reg    <= PH_IDLE;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
            mv_reg    <= 1'b0;
            start_div <= 1'b0;
            ax_reg    <= '0;
            valid_reg <= 1'b0;
            calib_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i]  <= '0;
                gain_reg[i] <= UNITY;
                last_reg[i] <= '0;
                fld_reg[i]  <= '0;
            end
        end else begin
            st_reg    <= st_next;
            start_div <= start_div_next;
            if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE: begin
                    ax_reg <= '0;
                    if (accept) begin
                        ph_reg    <= ph_next;
                        cnt_reg   <= cnt_next;
                        sat_reg   <= sat_next;
                        valid_reg <= s_data.req_type != REQ_START
                                     && ph_reg == PH_IDLE && s_data.bus_ack;
                        calib_reg <= s_data.req_type == REQ_START || ph_reg != PH_IDLE;
                        for (int i = 0; i < 3; i++) begin
                            sum_reg[i]  <= sum_next[i];
                            last_reg[i] <= last_next[i];
                            fld_reg[i]  <= '0;
                            if (s_data.req_type == REQ_START || (finish && sat_next)) begin
                                gain_reg[i] <= UNITY;
                            end
                        end
                    end
                end
                ST_SCALE: begin
                    fld_reg[ax_reg] <= sclip;
                    ax_reg <= ax_reg + 2'd1;
                end
                ST_DIV: begin
                    if (ddone) begin
                        gain_reg[ax_reg] <= dquot;
                    end
                end
                ST_DIV_NEXT: begin
                    ax_reg <= ax_reg + 2'd1;
                end
                ST_OUT: begin
                    mv_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_OUT) begin
            out_reg.reading_valid      <= valid_reg;
            out_reg.field_x            <= fld_reg[0];
            out_reg.field_y            <= fld_reg[1];
            out_reg.field_z            <= fld_reg[2];
            out_reg.calibrating        <= calib_reg;
            out_reg.calibration_failed <= sat_reg;
        end
    end

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn) (st_reg != ST_IDLE) |-> !s_ready;
    endproperty
    assert property (p_no_accept_busy) else $error("accept while busy");

    property p_out_once;
        @(posedge aclk) disable iff (!aresetn) (st_reg == ST_OUT) |=> mv_reg;
    endproperty
    assert property (p_out_once) else $error("result not presented");

    property p_valid_zero_fields;
        @(posedge aclk) disable iff (!aresetn)
            (mv_reg && !out_reg.reading_valid) |->
            (out_reg.field_x == 16'sd0 && out_reg.field_z == 16'sd0);
    endproperty
    assert property (p_valid_zero_fields) else $error("fields set without valid read");
endmodule

[dv/magnetometer_bias_self_test_gain_tb.sv]
// Testbench for magnetometer_bias_self_test_gain: drives start and read words,
// predicts each result word with a scoreboard class and compares field by field.
// Depends on mbst_pkg and the block's RTL only.
module magnetometer_bias_self_test_gain_tb
    import mbst_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSAMP = SAMPLES_PER_PHASE_DEF;
    localparam int FRAC = GAIN_FRACTION_BITS_DEF;
    localparam logic [15:0] UNITY = 16'(1 << FRAC);
    localparam logic REQ_READ = 1'b1;
    localparam int WATCHDOG_LIMIT = 20000;

    class gain_scoreboard;
        logic [15:0] ref_xy, ref_z;
        logic signed [15:0] sat_lim;
        phase_t phase;
        int unsigned count;
        logic signed [20:0] sum_x, sum_y, sum_z;
        logic sat_seen;
        logic [15:0] gx, gy, gz;
        logic signed [15:0] lx, ly, lz;
        out_word_t pending[$];
        int errors;

        function new();
            ref_xy = REF_XY_RST;
            ref_z = REF_Z_RST;
            sat_lim = SAT_LIM_RST;
            phase = PH_IDLE;
            count = 0;
            sum_x = 0; sum_y = 0; sum_z = 0;
            sat_seen = 0;
            gx = UNITY; gy = UNITY; gz = UNITY;
            lx = 0; ly = 0; lz = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_REF_XY: ref_xy = val;
                CFG_REF_Z: ref_z = val;
                CFG_SAT_LIM: sat_lim = val;
                default: ;
            endcase
        endfunction

        function logic [15:0] gain_from(logic [15:0] num, logic signed [20:0] total);
            longint mag, q;
            mag = total < 0 ? -longint'(total) : longint'(total);
            if (mag == 0) return 16'hFFFF;
            q = (longint'(num) << FRAC) / mag;
            return q > 65535 ? 16'hFFFF : 16'(q);
        endfunction

        function logic signed [15:0] scaled(logic signed [15:0] raw, logic [15:0] g);
            longint p, mag, r;
            p = longint'(raw) * longint'(g);
            mag = (p < 0 ? -p : p) >> FRAC;
            r = p < 0 ? -mag : mag;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return 16'(r);
        endfunction

        function void note_input(in_word_t w);
            out_word_t o;
            logic sat;
            o = '0;
            if (w.req_type == REQ_START) begin
                gx = UNITY; gy = UNITY; gz = UNITY;
                phase = PH_DISCARD;
                count = 0;
                sat_seen = 0;
                sum_x = 0; sum_y = 0; sum_z = 0;
                o.calibrating = 1;
            end else begin
                if (w.bus_ack) begin
                    lx = {w.byte_x_high, w.byte_x_low};
                    lz = {w.byte_z_high, w.byte_z_low};
                    ly = {w.byte_y_high, w.byte_y_low};
                end
                if (phase == PH_IDLE) begin
                    if (w.bus_ack) begin
                        o.reading_valid = 1;
                        o.field_x = scaled(lx, gx);
                        o.field_y = scaled(ly, gy);
                        o.field_z = scaled(lz, gz);
                    end
                end else if (phase == PH_DISCARD) begin
                    o.calibrating = 1;
                    phase = PH_POSITIVE;
                    count = 0;
                end else begin
                    sat = lx <= sat_lim || ly <= sat_lim || lz <= sat_lim;
                    o.calibrating = 1;
                    count = (count + 1) & 15;
                    if (sat) sat_seen = 1;
                    if (phase == PH_POSITIVE) begin
                        sum_x += lx; sum_y += ly; sum_z += lz;
                        if (sat || count >= NSAMP) begin
                            phase = PH_NEGATIVE;
                            count = 0;
                        end
                    end else begin
                        sum_x -= lx; sum_y -= ly; sum_z -= lz;
                        if (sat || count >= NSAMP) begin
                            if (sat_seen) begin
                                gx = UNITY; gy = UNITY; gz = UNITY;
                            end else begin
                                gx = gain_from(ref_xy, sum_x);
                                gy = gain_from(ref_xy, sum_y);
                                gz = gain_from(ref_z, sum_z);
                            end
                            phase = PH_IDLE;
                            count = 0;
                        end
                    end
                end
            end
            o.calibration_failed = sat_seen;
            pending.push_back(o);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(out_word_t got);
            out_word_t e;
            if (pending.size() == 0) begin
                $display("mismatch: result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.reading_valid !== e.reading_valid)
                report("reading_valid", got.reading_valid, e.reading_valid);
            if (got.field_x !== e.field_x) report("field_x", got.field_x, e.field_x);
            if (got.field_y !== e.field_y) report("field_y", got.field_y, e.field_y);
            if (got.field_z !== e.field_z) report("field_z", got.field_z, e.field_z);
            if (got.calibrating !== e.calibrating)
                report("calibrating", got.calibrating, e.calibrating);
            if (got.calibration_failed !== e.calibration_failed)
                report("calibration_failed", got.calibration_failed, e.calibration_failed);
        endtask
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    out_word_t m_data;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    gain_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    magnetometer_bias_self_test_gain dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_input(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off)
            m_ready <= 0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("magnetometer_bias_self_test_gain regression: fail");
            $finish;
        end
    end

    task send_word(in_word_t w);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_valid <= 1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    function in_word_t read_word(logic ack, logic signed [15:0] x,
                                 logic signed [15:0] y, logic signed [15:0] z);
        in_word_t w;
        w.req_type = REQ_READ;
        w.bus_ack = ack;
        {w.byte_x_high, w.byte_x_low} = x;
        {w.byte_z_high, w.byte_z_low} = z;
        {w.byte_y_high, w.byte_y_low} = y;
        return w;
    endfunction

    function in_word_t start_word();
        in_word_t w;
        w = in_word_t'({$urandom, $urandom});
        w.req_type = REQ_START;
        return w;
    endfunction

    function logic signed [15:0] bias_sample(int lo, int hi);
        return 16'($urandom_range(hi - lo) + lo);
    endfunction

    // one self-test: start, discard, positive then negative bias reads
    task run_self_test(bit big);
        int n;
        in_word_t w;
        send_word(start_word());
        send_word(read_word($urandom_range(1), 16'($urandom), 16'($urandom), 16'($urandom)));
        n = $urandom_range(2 * NSAMP + 2);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                w = read_word(0, 16'($urandom), 16'($urandom), 16'($urandom));
            end else if ($urandom_range(14) == 0) begin
                w = read_word(1, 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (i < NSAMP) begin
                w = read_word(1, bias_sample(big ? 0 : 900, big ? 3000 : 1800),
                              bias_sample(900, 1800), bias_sample(800, 1700));
            end else begin
                w = read_word(1, bias_sample(-1800, -900), bias_sample(-1800, -900),
                              bias_sample(-1700, -800));
            end
            send_word(w);
        end
    endtask

    task random_reads(int n);
        for (int i = 0; i < n; i++)
            send_word(read_word($urandom_range(7) != 0, 16'($urandom), 16'($urandom),
                                16'($urandom)));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, failed reads, zero totals, saturation, restart
        send_word(read_word(1, 16'sh7FFF, -16'sd32768, 16'sd0));
        send_word(read_word(1, 16'hFFFF, 16'h0001, 16'h8001));
        send_word(read_word(0, 16'h1234, 16'h5678, 16'h9ABC));
        send_word(start_word());
        send_word(read_word(1, 0, 0, 0));
        for (int i = 0; i < 2 * NSAMP; i++) send_word(read_word(i % 3 != 0, 5, 5, 5));
        send_word(read_word(1, 16'sh7FFF, -16'sd32768, 16'sd100));
        send_word(start_word());
        send_word(read_word(1, 0, 0, 0));
        send_word(read_word(1, 100, -5000, 100));
        send_word(read_word(1, -4096, 100, 100));
        send_word(read_word(1, 300, 300, 300));
        send_word(start_word());
        send_word(start_word());
        drain();

        write_reg(CFG_REF_XY, 16'hFFFF);
        write_reg(CFG_REF_Z, 16'h0000);
        write_reg(CFG_SAT_LIM, 16'h8000);
        run_self_test(1);
        random_reads(20);
        drain();
        write_reg(CFG_REF_XY, 16'h0000);
        write_reg(CFG_REF_Z, 16'hFFFF);
        write_reg(CFG_SAT_LIM, 16'h0000);
        run_self_test(0);
        random_reads(10);
        drain();
        write_reg(CFG_REF_XY, REF_XY_RST);
        write_reg(CFG_REF_Z, REF_Z_RST);
        write_reg(CFG_SAT_LIM, SAT_LIM_RST);

        for (int phs = 0; phs < 4; phs++) begin
            send_idle_pct = (phs == 1 || phs == 3) ? (phs == 3 ? 12 : 62) : 0;
            recv_stall_pct = (phs == 2 || phs == 3) ? (phs == 3 ? 12 : 62) : 0;
            if (phs == 2) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge aclk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int k = 0; k < 6; k++) begin
                run_self_test($urandom_range(1));
                random_reads(6);
            end
            drain();
            write_reg(CFG_REF_XY, 16'($urandom));
            write_reg(CFG_REF_Z, 16'($urandom));
            write_reg(CFG_SAT_LIM, 16'(-$urandom_range(32768)));
        end
        recv_stall_pct = 0;
        drain();

        if (sb.errors == 0)
            $display("magnetometer_bias_self_test_gain regression: pass");
        else
            $display("magnetometer_bias_self_test_gain regression: fail");
        $finish;
    end
endmodule
